### rtl/core/mbet_pkg.sv
// Package for the Mandelbrot escape-time core.
// Holds fixed-point constants, register indexes, FSM states and control structs.
// No dependencies.
package mbet_pkg;

    localparam int TILE_PIXELS = 256;
    localparam int TILE_LOG2   = $clog2(TILE_PIXELS);
    localparam int FRAC_BITS   = 28;
    localparam int Q_W         = 32;
    localparam int SPAN_W      = 31;
    localparam int ITER_W      = 16;
    localparam int COORD_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int SUM_W       = 38;
    localparam int PROD_W      = COORD_W + SPAN_W;

    localparam logic signed [SUM_W-1:0] ESCAPE_LIMIT = SUM_W'(64'sd4 <<< FRAC_BITS);
    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(-64'sd2147483648);

    localparam logic signed [Q_W-1:0]  RST_LEFT  = -32'sd536870912;
    localparam logic signed [Q_W-1:0]  RST_TOP   = 32'sd536870912;
    localparam logic [SPAN_W-1:0]      RST_SPAN  = 31'd1073741824;
    localparam logic [ITER_W-1:0]      RST_MAX   = 16'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_SPAN_X = 3'd2,
        CFG_SPAN_Y = 3'd3,
        CFG_MAX_IT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ITER
    } t_state;

    typedef struct packed {
        logic load_in;
        logic setup;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic stop;
    } t_status;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[Q_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/mbet_in_if.sv
// Pixel request channel: valid/ready with column and row.
// Depends on mbet_pkg.
interface mbet_in_if;
    logic                          valid;
    logic                          ready;
    logic [mbet_pkg::COORD_W-1:0]  col;
    logic [mbet_pkg::COORD_W-1:0]  row;

    modport source (output valid, col, row, input ready);
    modport sink   (input valid, col, row, output ready);
endinterface

### rtl/core/mbet_out_if.sv
// Pixel result channel: valid/ready with count, gray byte and pixel index.
// Depends on mbet_pkg.
interface mbet_out_if;
    logic                          valid;
    logic                          ready;
    logic [mbet_pkg::ITER_W-1:0]   iterations;
    logic [7:0]                    gray;
    logic [15:0]                   pixel_index;

    modport source (output valid, iterations, gray, pixel_index, input ready);
    modport sink   (input valid, iterations, gray, pixel_index, output ready);
endinterface

### rtl/core/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core: top level joining controller and datapath.
// Depends on mbet_pkg, mbet_in_if, mbet_out_if, mbet_ctrl, mbet_dp.

// Each accepted pixel (col, row) is mapped to c = left + col*span_x/TILE_PIXELS
// + i*(top - row*span_y/TILE_PIXELS) in signed Q4.28 and iterated z = z^2 + c
// until |z|^2 >= 4 or max_iterations is reached. One pixel is in flight at a
// time: it is accepted, its point is mapped, then it iterates at one iteration
// per cycle (three 32x32 multipliers in the update loop) and is retired. The
// result sits in an output register, so a new pixel is accepted while the
// previous result waits for its transfer; a finished pixel holds in the retire
// cycle until that register is free.
// Configuration writes must only be made while no pixel is in flight.
module mandelbrot_escape_time_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbet_pkg::Q_W-1:0]         i_cfg_wdata,
    mbet_in_if.sink                          i_pix,
    mbet_out_if.source                       o_res
);

    mbet_pkg::t_cmd    cmd;
    mbet_pkg::t_status status;

    mbet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mbet_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_col         (i_pix.col),
        .i_row         (i_pix.row),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_iterations  (o_res.iterations),
        .o_gray        (o_res.gray),
        .o_pixel_index (o_res.pixel_index)
    );

endmodule

### rtl/core/mbet_ctrl.sv
// Controller FSM: sequences setup, iteration and result transfer.
// Depends on mbet_pkg.
module mbet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mbet_pkg::t_status i_status,
    output mbet_pkg::t_cmd    o_cmd
);

    mbet_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mbet_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = mbet_pkg::ST_SETUP;
            end
            mbet_pkg::ST_SETUP: begin
                n_state = mbet_pkg::ST_ITER;
            end
            mbet_pkg::ST_ITER: begin
                if (i_status.stop && slot_free) n_state = mbet_pkg::ST_IDLE;
            end
            default: begin
                n_state = mbet_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            mbet_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            mbet_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            mbet_pkg::ST_ITER: begin
                o_cmd.step = !i_status.stop;
                o_cmd.emit = i_status.stop && slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbet_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/mbet_dp.sv
// Datapath: config registers, point mapping, z^2 + c iteration and result register.
// Depends on mbet_pkg.
module mbet_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbet_pkg::Q_W-1:0]         i_cfg_wdata,
    input  logic [mbet_pkg::COORD_W-1:0]     i_col,
    input  logic [mbet_pkg::COORD_W-1:0]     i_row,
    input  mbet_pkg::t_cmd                   i_cmd,
    output mbet_pkg::t_status                o_status,
    output logic [mbet_pkg::ITER_W-1:0]      o_iterations,
    output logic [7:0]                       o_gray,
    output logic [15:0]                      o_pixel_index
);

    localparam int SW = mbet_pkg::SUM_W;
    localparam int QW = mbet_pkg::Q_W;

    logic signed [QW-1:0]                 r_left, r_top;
    logic [mbet_pkg::SPAN_W-1:0]          r_span_x, r_span_y;
    logic [mbet_pkg::ITER_W-1:0]          r_max_it;

    logic [mbet_pkg::COORD_W-1:0]         r_col, r_row;
    logic signed [QW-1:0]                 r_x0, r_y0, r_x, r_y;
    logic [mbet_pkg::ITER_W-1:0]          r_n;
    logic [mbet_pkg::ITER_W-1:0]          r_out_iter;
    logic [7:0]                           r_out_gray;
    logic [15:0]                          r_out_index;

    logic [mbet_pkg::PROD_W-1:0]          w_prod_x, w_prod_y;
    logic signed [SW-1:0]                 s_offx, s_offy, s_x0, s_y0;
    logic signed [2*QW-1:0]               p_xx, p_yy, p_xy;
    logic signed [SW-1:0]                 s_xs, s_ys, s_xy, s_nx, s_ny;
    logic                                 escaped;
    logic [31:0]                          w_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= mbet_pkg::RST_LEFT;
            r_top    <= mbet_pkg::RST_TOP;
            r_span_x <= mbet_pkg::RST_SPAN;
            r_span_y <= mbet_pkg::RST_SPAN;
            r_max_it <= mbet_pkg::RST_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbet_pkg::CFG_LEFT:   r_left   <= i_cfg_wdata;
                mbet_pkg::CFG_TOP:    r_top    <= i_cfg_wdata;
                mbet_pkg::CFG_SPAN_X: r_span_x <= i_cfg_wdata[mbet_pkg::SPAN_W-1:0];
                mbet_pkg::CFG_SPAN_Y: r_span_y <= i_cfg_wdata[mbet_pkg::SPAN_W-1:0];
                mbet_pkg::CFG_MAX_IT: r_max_it <= i_cfg_wdata[mbet_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Point mapping: offset = col * span / TILE_PIXELS, truncated.
    assign w_prod_x = mbet_pkg::PROD_W'(r_col) * mbet_pkg::PROD_W'(r_span_x);
    assign w_prod_y = mbet_pkg::PROD_W'(r_row) * mbet_pkg::PROD_W'(r_span_y);
    assign s_offx   = signed'(SW'(w_prod_x >> mbet_pkg::TILE_LOG2));
    assign s_offy   = signed'(SW'(w_prod_y >> mbet_pkg::TILE_LOG2));
    assign s_x0     = SW'(r_left) + s_offx;
    assign s_y0     = SW'(r_top) - s_offy;

    // One iteration per cycle; products round toward minus infinity.
    assign p_xx    = r_x * r_x;
    assign p_yy    = r_y * r_y;
    assign p_xy    = r_x * r_y;
    assign s_xs    = SW'(p_xx >>> mbet_pkg::FRAC_BITS);
    assign s_ys    = SW'(p_yy >>> mbet_pkg::FRAC_BITS);
    assign s_xy    = SW'(p_xy >>> (mbet_pkg::FRAC_BITS - 1));
    assign s_nx    = s_xs - s_ys + SW'(r_x0);
    assign s_ny    = s_xy + SW'(r_y0);
    assign escaped = (s_xs + s_ys) >= mbet_pkg::ESCAPE_LIMIT;

    assign o_status.stop = escaped || (r_n >= r_max_it);

    assign w_index = (32'(r_row) << mbet_pkg::TILE_LOG2) + 32'(r_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        if (i_cmd.setup) begin
            r_x0 <= mbet_pkg::sat_q(s_x0);
            r_y0 <= mbet_pkg::sat_q(s_y0);
            r_x  <= '0;
            r_y  <= '0;
            r_n  <= '0;
        end else if (i_cmd.step) begin
            r_x  <= mbet_pkg::sat_q(s_nx);
            r_y  <= mbet_pkg::sat_q(s_ny);
            r_n  <= r_n + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_iter  <= r_n;
            r_out_gray  <= r_n[7:0];
            r_out_index <= w_index[15:0];
        end
    end

    assign o_iterations  = r_out_iter;
    assign o_gray        = r_out_gray;
    assign o_pixel_index = r_out_index;

endmodule

### rtl/core/mbet_checker.sv
// Port-level checker for the Mandelbrot escape-time core, with its bind.
// Depends on mbet_pkg and mandelbrot_escape_time_core.
module mbet_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [mbet_pkg::ITER_W-1:0]    i_iterations,
    input  logic [7:0]                     i_gray,
    input  logic [15:0]                    i_pixel_index
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_iterations)
            && $stable(i_gray) && $stable(i_pixel_index))
        else $error("result changed while stalled");

    // One pixel in flight: no transfer right after a transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_gray == i_iterations[7:0])
        else $error("gray byte differs from count");

    // A new result only comes out of the busy phase.
    a_retire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

endmodule

bind mandelbrot_escape_time_core mbet_checker u_mbet_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_iterations  (o_res.iterations),
    .i_gray        (o_res.gray),
    .i_pixel_index (o_res.pixel_index)
);
